### hdl/mcld_pkg.sv
// Shared types, codes and helper functions of the motor command line decoder.
// Depends on nothing; every other file of the block but mcld_checker imports it.
package mcld_pkg;

    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_TAB   = 8'h09;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_ONE   = 8'h31;
    localparam logic [7:0] ASCII_TWO   = 8'h32;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_V     = 8'h56;
    localparam logic [7:0] ASCII_R     = 8'h52;

    // Line positions that the decoder reads
    localparam int DEC_BYTES = 12;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_FULL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_SEL0   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_SEL1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_SEL2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_DEFLT  = 3'd6;

    // Duty saturates once span*speed reaches 256*100
    localparam logic [19:0] DUTY_SAT_LIMIT = 20'd25600;
    // 2^19/100 rounded up; exact quotient for products below the limit
    localparam logic [12:0] RECIP_100 = 13'd5243;

    typedef struct packed {
        logic [7:0] unit_first;
        logic [7:0] unit_second;
        logic [7:0] span_full;
        logic [7:0] span_sel0;
        logic [7:0] span_sel1;
        logic [7:0] span_sel2;
        logic [7:0] span_deflt;
    } cfg_t;

    typedef enum logic [1:0] {
        DIR_KEEP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        RD_SKIP  = 3'b001,
        RD_DIGIT = 3'b010,
        RD_DONE  = 3'b100
    } rd_phase_t;

    // Decoded line, handed from the line stage to the duty stage
    typedef struct packed {
        logic               accept;
        logic [7:0]         span;
        logic signed [10:0] speed_one;
        logic signed [10:0] speed_two;
        dir_t               dir_one;
        dir_t               dir_two;
    } job_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == ASCII_SPACE) || ((c >= ASCII_TAB) && (c <= ASCII_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
    endfunction

    // Three-character decimal read: skip blanks, one sign, then digits
    function automatic logic signed [10:0] read_three(input logic [7:0] c0,
                                                      input logic [7:0] c1,
                                                      input logic [7:0] c2);
        logic [7:0] ch [3];
        rd_phase_t  ph;
        logic       neg;
        logic [9:0] val;
        ch[0] = c0;
        ch[1] = c1;
        ch[2] = c2;
        ph    = RD_SKIP;
        neg   = 1'b0;
        val   = 10'd0;
        for (int k = 0; k < 3; k++) begin
            unique case (ph)
                RD_SKIP: begin
                    if (is_blank(ch[k])) begin
                        ph = RD_SKIP;
                    end else if (ch[k] == ASCII_PLUS || ch[k] == ASCII_MINUS) begin
                        neg = (ch[k] == ASCII_MINUS);
                        ph  = RD_DIGIT;
                    end else if (is_digit(ch[k])) begin
                        val = {6'd0, ch[k][3:0]};
                        ph  = RD_DIGIT;
                    end else begin
                        ph = RD_DONE;
                    end
                end
                RD_DIGIT: begin
                    if (is_digit(ch[k])) begin
                        val = 10'(val * 10'd10 + {6'd0, ch[k][3:0]});
                    end else begin
                        ph = RD_DONE;
                    end
                end
                default: ph = RD_DONE;
            endcase
        end
        return neg ? -$signed({1'b0, val}) : $signed({1'b0, val});
    endfunction

    function automatic dir_t dir_of(input logic [7:0] c);
        if (c == ASCII_V) begin
            return DIR_FWD;
        end else if (c == ASCII_R) begin
            return DIR_REV;
        end
        return DIR_KEEP;
    endfunction

endpackage

### hdl/mcld_cfg_regs.sv
// Configuration register file of the motor command line decoder.
// Depends on mcld_pkg for the register indexes and cfg_t.
module mcld_cfg_regs
    import mcld_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [7:0]           wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            cfg_reg.unit_first  <= 8'd77;
            cfg_reg.unit_second <= 8'd49;
            cfg_reg.span_full   <= 8'd255;
            cfg_reg.span_sel0   <= 8'd230;
            cfg_reg.span_sel1   <= 8'd209;
            cfg_reg.span_sel2   <= 8'd192;
            cfg_reg.span_deflt  <= 8'd100;
        end else if (wr_en) begin
            unique case (wr_index)
                CFG_UNIT_FIRST:  cfg_reg.unit_first  <= wr_data;
                CFG_UNIT_SECOND: cfg_reg.unit_second <= wr_data;
                CFG_SPAN_FULL:   cfg_reg.span_full   <= wr_data;
                CFG_SPAN_SEL0:   cfg_reg.span_sel0   <= wr_data;
                CFG_SPAN_SEL1:   cfg_reg.span_sel1   <= wr_data;
                CFG_SPAN_SEL2:   cfg_reg.span_sel2   <= wr_data;
                CFG_SPAN_DEFLT:  cfg_reg.span_deflt  <= wr_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/mcld_line_stage.sv
// Line store, byte count and line decode of the motor command line decoder.
// Depends on mcld_pkg for the ASCII codes, read_three, dir_of and job_t.
module mcld_line_stage
    import mcld_pkg::*;
#(
    parameter int LINE_LEN = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic       byte_ready,
    output logic       job_valid,
    input  logic       job_ready,
    output job_t       job
);

    localparam int CNT_W = $clog2(LINE_LEN + 1);
    localparam int IDX_W = $clog2(LINE_LEN);

    logic [7:0]       store_reg [LINE_LEN];
    logic [CNT_W-1:0] count_reg;
    logic             job_valid_reg;
    job_t             job_reg;

    logic             is_end;
    logic             not_full;
    logic             job_free;
    logic             take;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       eff [DEC_BYTES];
    logic [7:0]       span;
    job_t             job_next;

    assign not_full   = (count_reg < CNT_W'(LINE_LEN));
    assign is_end     = (byte_data == ASCII_LF) || (byte_data == ASCII_CR) || !not_full;
    assign job_free   = !job_valid_reg || job_ready;
    // A stored byte moves on at once; a line end needs room for its job
    assign byte_ready = !is_end || job_free;
    assign take       = byte_valid && byte_ready;
    assign wr_idx     = count_reg[IDX_W-1:0];

    // Store as the decoder sees it, with the zero mark of this line end applied
    always_comb begin
        for (int j = 0; j < DEC_BYTES; j++) begin
            eff[j] = (count_reg == CNT_W'(j)) ? 8'h00 : store_reg[j];
        end
    end

    always_comb begin
        if (eff[10] == ASCII_ZERO) begin
            span = cfg.span_full;
        end else if (eff[11] == ASCII_ZERO) begin
            span = cfg.span_sel0;
        end else if (eff[11] == ASCII_ONE) begin
            span = cfg.span_sel1;
        end else if (eff[11] == ASCII_TWO) begin
            span = cfg.span_sel2;
        end else begin
            span = cfg.span_deflt;
        end
        job_next.accept    = (eff[0] == cfg.unit_first) && (eff[1] == cfg.unit_second);
        job_next.span      = span;
        job_next.speed_one = read_three(eff[3], eff[4], eff[5]);
        job_next.speed_two = read_three(eff[7], eff[8], eff[9]);
        job_next.dir_one   = dir_of(eff[2]);
        job_next.dir_two   = dir_of(eff[6]);
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            count_reg <= '0;
            for (int j = 0; j < LINE_LEN; j++) begin
                store_reg[j] <= 8'h00;
            end
        end else if (take) begin
            if (!is_end) begin
                store_reg[wr_idx] <= byte_data;
                count_reg         <= CNT_W'(count_reg + 1'b1);
            end else begin
                if (not_full) begin
                    store_reg[wr_idx] <= 8'h00;
                end
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            job_valid_reg <= 1'b0;
        end else if (job_free) begin
            job_valid_reg <= take && is_end;
        end
    end

    always_ff @(posedge clk) begin
        if (job_free && take && is_end) begin
            job_reg <= job_next;
        end
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule

### hdl/mcld_duty_stage.sv
// Duty arithmetic, saturation, direction pins and result register.
// Depends on mcld_pkg for job_t, dir_t and the duty constants.
module mcld_duty_stage
    import mcld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    output logic       job_ready,
    input  job_t       job,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] duty_one,
    output logic [7:0] duty_two,
    output logic [3:0] pins
);

    logic               prod_valid_reg;
    logic               prod_accept_reg;
    logic signed [19:0] prod_one_reg;
    logic signed [19:0] prod_two_reg;
    dir_t               dir_one_reg;
    dir_t               dir_two_reg;

    logic               res_valid_reg;
    logic [7:0]         duty_one_reg;
    logic [7:0]         duty_two_reg;
    logic [3:0]         pins_reg;
    logic [7:0]         duty_one_next;
    logic [7:0]         duty_two_next;
    logic [3:0]         pins_next;
    logic               res_free;

    function automatic logic [7:0] sat_duty(input logic signed [19:0] p);
        logic [27:0] scaled;
        scaled = {13'd0, p[14:0]} * {15'd0, RECIP_100};
        if (p < 0) begin
            return 8'd0;
        end else if (p >= $signed(DUTY_SAT_LIMIT)) begin
            return 8'hFF;
        end
        return scaled[26:19];
    endfunction

    assign res_free  = !res_valid_reg || res_ready;
    assign job_ready = !prod_valid_reg || res_free;

    // Product stage
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            prod_valid_reg <= 1'b0;
        end else if (job_ready) begin
            prod_valid_reg <= job_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (job_ready && job_valid) begin
            prod_accept_reg <= job.accept;
            prod_one_reg    <= 20'($signed({1'b0, job.span}) * job.speed_one);
            prod_two_reg    <= 20'($signed({1'b0, job.span}) * job.speed_two);
            dir_one_reg     <= job.dir_one;
            dir_two_reg     <= job.dir_two;
        end
    end

    // Result stage: duties and pins are held state, updated by accepted lines
    always_comb begin
        duty_one_next = sat_duty(prod_one_reg);
        duty_two_next = sat_duty(prod_two_reg);
        pins_next     = pins_reg;
        case (dir_two_reg)
            DIR_FWD: pins_next[3:2] = 2'b01;
            DIR_REV: pins_next[3:2] = 2'b10;
            default: ;
        endcase
        case (dir_one_reg)
            DIR_FWD: pins_next[1:0] = 2'b10;
            DIR_REV: pins_next[1:0] = 2'b01;
            default: ;
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
            duty_one_reg  <= 8'd0;
            duty_two_reg  <= 8'd0;
            pins_reg      <= 4'hF;
        end else if (res_free) begin
            res_valid_reg <= prod_valid_reg;
            if (prod_valid_reg && prod_accept_reg) begin
                duty_one_reg <= duty_one_next;
                duty_two_reg <= duty_two_next;
                pins_reg     <= pins_next;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign duty_one  = duty_one_reg;
    assign duty_two  = duty_two_reg;
    assign pins      = pins_reg;

endmodule

### hdl/motor_command_line_decoder_core.sv
// Top level of the motor command line decoder: input register, line stage,
// duty stage and configuration registers. Depends on mcld_pkg and all hdl modules but mcld_checker.
//
// Usage:
//   s_axis: one received serial byte per transfer in s_tdata[7:0]. CR or LF
//     ends a line, as does any byte arriving after LINE_LEN stored bytes.
//   m_axis: one result per ended line, carrying the current duties and
//     direction pins. Lines with a foreign unit id still report, unchanged.
//   cfg: write channel; cfg_index selects one of seven 8-bit registers,
//     indexes past the list are dropped. cfg_ready is always high. Write
//     only while no line is in flight.
// Path: a line end accepted on s_axis passes the input register, the line
//   decode, product and saturating result registers before it shows on m_axis.
// Throughput: one byte per cycle unless a line end waits for room; the
//   product is registered ahead of the divide-by-100 reciprocal multiply, which sets the depth.
// Stall: each stage advances when its successor is empty or moving, so bytes
//   keep coming in while a result waits, until a line end finds the pipeline full.
// Reset: aresetn low clears the line store, count, duties (0) and pins (all
//   ones), empties the pipeline and restores register defaults.
module motor_command_line_decoder_core
    import mcld_pkg::*;
#(
    parameter int LINE_LEN = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: [7:0] rx_byte
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    // m_tdata: [7:0] duty_one, [15:8] duty_two, [16] m1_pin_a, [17] m1_pin_b,
    //          [18] m2_pin_a, [19] m2_pin_b, [23:20] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       line_ready;
    logic       job_valid;
    logic       job_ready;
    job_t       job;
    logic [7:0] duty_one;
    logic [7:0] duty_two;
    logic [3:0] pins;

    assign cfg_ready = 1'b1;

    mcld_cfg_regs u_cfg (
        .clk      (aclk),
        .rst_n    (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Input register: take a byte when empty or when the held one moves on
    assign s_tready = !in_valid_reg || line_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    mcld_line_stage #(
        .LINE_LEN (LINE_LEN)
    ) u_line (
        .clk        (aclk),
        .rst_n      (aresetn),
        .cfg        (cfg),
        .byte_valid (in_valid_reg),
        .byte_data  (in_byte_reg),
        .byte_ready (line_ready),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job)
    );

    mcld_duty_stage u_duty (
        .clk       (aclk),
        .rst_n     (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .duty_one  (duty_one),
        .duty_two  (duty_two),
        .pins      (pins)
    );

    // Pins: bit0 m1_pin_a, bit1 m1_pin_b, bit2 m2_pin_a, bit3 m2_pin_b
    assign m_tdata = {4'd0, pins, duty_two, duty_one};

endmodule

### hdl/mcld_checker.sv
// Port-level checks of the motor command line decoder, bound to the top level.
// Depends on motor_command_line_decoder_core for its port names.
module mcld_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // A reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // Motor one pins start both high and never go both low
    a_m1_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[17:16] != 2'b00))
        else $error("motor one pins both low");

    a_m2_pins: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[19:18] != 2'b00))
        else $error("motor two pins both low");

endmodule

bind motor_command_line_decoder_core mcld_checker u_mcld_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
